/* design/i2cms_pkg.sv */
package i2cms_pkg;

  localparam int TX_DEPTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_START_WR  = 2'd1,
    CMD_START_RD  = 2'd2,
    CMD_BUS_EVENT = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_ADDR_WR   = 4'd1,
    ACT_ADDR_RD   = 4'd2,
    ACT_ADDR_RD1  = 4'd3,
    ACT_DATA      = 4'd4,
    ACT_STOP      = 4'd5,
    ACT_ACK_CONT  = 4'd6,
    ACT_NACK_STOP = 4'd7,
    ACT_RECOVERY  = 4'd8
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_WR_ADDR      = 4'd1,
    PH_WR_ADDR_ACK  = 4'd2,
    PH_WR_ADDR_NACK = 4'd3,
    PH_WR_DATA_ACK  = 4'd4,
    PH_WR_DATA_NACK = 4'd5,
    PH_RD_ADDR      = 4'd6,
    PH_RD_ADDR_NACK = 4'd7,
    PH_RD_ACK       = 4'd8,
    PH_RD_NACK      = 4'd9,
    PH_ARB_LOST     = 4'd10,
    PH_BUS_ERR      = 4'd11
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] target;
    logic [7:0] byte_count;
    logic [3:0] slot;
    logic [7:0] data_byte;
    logic       write_flag;
    logic       arb_lost;
    logic       bus_fault;
    logic       nack_seen;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] action;
    logic [7:0] bus_address;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       busy_res;
    logic [3:0] phase;
  } res_t;

  // A decoded transaction as it waits between the front and the back end.
  typedef struct packed {
    cmd_e       kind;
    logic       ok;       // load slot in range, or start command legal
    logic       single;   // read of exactly one byte
    logic [6:0] target;
    logic [7:0] byte_count;
    logic [3:0] slot;
    logic [7:0] data_byte;
    logic       write_flag;
    logic       arb_lost;
    logic       bus_fault;
    logic       nack_seen;
  } cls_t;

endpackage

/* design/i2cms_front.sv */
module i2cms_front #(
  parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEFAULT
) (
  input  i2cms_pkg::req_t req_i,
  output i2cms_pkg::cls_t cls_o
);

  logic [8:0] slot_ext;
  logic [8:0] cnt_ext;
  i2cms_pkg::cmd_e kind;

  assign slot_ext = {5'b0, req_i.slot};
  assign cnt_ext  = {1'b0, req_i.byte_count};
  assign kind     = i2cms_pkg::cmd_e'(req_i.command);

  always_comb begin
    cls_o.kind       = kind;
    cls_o.single     = (req_i.byte_count == 8'd1);
    cls_o.target     = req_i.target;
    cls_o.byte_count = req_i.byte_count;
    cls_o.slot       = req_i.slot;
    cls_o.data_byte  = req_i.data_byte;
    cls_o.write_flag = req_i.write_flag;
    cls_o.arb_lost   = req_i.arb_lost;
    cls_o.bus_fault  = req_i.bus_fault;
    cls_o.nack_seen  = req_i.nack_seen;
    unique case (kind)
      i2cms_pkg::CMD_LOAD:      cls_o.ok = (slot_ext < 9'(TX_DEPTH));
      i2cms_pkg::CMD_START_WR:  cls_o.ok = (cnt_ext <= 9'(TX_DEPTH));
      i2cms_pkg::CMD_START_RD:  cls_o.ok = (req_i.byte_count != 8'd0);
      i2cms_pkg::CMD_BUS_EVENT: cls_o.ok = 1'b1;
      default:                  cls_o.ok = 1'b0;
    endcase
  end

endmodule

/* design/i2cms_queue.sv */
module i2cms_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cms_pkg::cls_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output i2cms_pkg::cls_t head_o
);

  localparam int Depth = i2cms_pkg::QUEUE_DEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  i2cms_pkg::cls_t entry_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/i2cms_back.sv */
module i2cms_back #(
  parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  i2cms_pkg::cls_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i2cms_pkg::res_t out_data_o
);

  localparam int IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int CW = $clog2(TX_DEPTH + 1);

  i2cms_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0]     tx_total_q, tx_total_d;
  logic [CW-1:0]     tx_pos_q, tx_pos_d;
  logic [7:0]        rx_total_q, rx_total_d;
  logic [7:0]        rx_pos_q, rx_pos_d;
  logic [6:0]        target_q, target_d;
  logic              busy_q, busy_d;
  logic              out_valid_q;
  i2cms_pkg::res_t   out_q, res;

  logic [7:0]        mem [TX_DEPTH];
  logic [7:0]        rd_q;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [8:0]        slot_ext, cnt_ext, rx_need;
  i2cms_pkg::phase_e ph;

  assign pop_o       = head_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign slot_ext  = {5'b0, head_i.slot};
  assign cnt_ext   = {1'b0, head_i.byte_count};
  assign rx_need   = {1'b0, rx_pos_q} + 9'd2;
  assign mem_we    = pop_o && (head_i.kind == i2cms_pkg::CMD_LOAD) && head_i.ok;
  assign mem_waddr = slot_ext[IW-1:0];
  assign mem_raddr = tx_pos_d[IW-1:0];

  // Phase as decoded from a bus event.
  always_comb begin
    if (head_i.write_flag) begin
      priority if (head_i.arb_lost) begin
        ph = i2cms_pkg::PH_ARB_LOST;
      end else if (head_i.bus_fault) begin
        ph = i2cms_pkg::PH_BUS_ERR;
      end else if (head_i.nack_seen) begin
        priority if (phase_q == i2cms_pkg::PH_WR_ADDR) begin
          ph = i2cms_pkg::PH_WR_ADDR_NACK;
        end else if (phase_q == i2cms_pkg::PH_RD_ADDR) begin
          ph = i2cms_pkg::PH_RD_ADDR_NACK;
        end else if (phase_q == i2cms_pkg::PH_WR_ADDR_ACK ||
                     phase_q == i2cms_pkg::PH_WR_DATA_ACK) begin
          ph = i2cms_pkg::PH_WR_DATA_NACK;
        end else begin
          ph = i2cms_pkg::PH_BUS_ERR;
        end
      end else begin
        ph = (phase_q == i2cms_pkg::PH_WR_ADDR) ? i2cms_pkg::PH_WR_ADDR_ACK
                                                : i2cms_pkg::PH_WR_DATA_ACK;
      end
    end else begin
      ph = head_i.nack_seen ? i2cms_pkg::PH_RD_NACK : i2cms_pkg::PH_RD_ACK;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    tx_total_d = tx_total_q;
    tx_pos_d   = tx_pos_q;
    rx_total_d = rx_total_q;
    rx_pos_d   = rx_pos_q;
    target_d   = target_q;
    busy_d     = busy_q;
    res        = '0;
    if (pop_o) begin
      unique case (head_i.kind)
        i2cms_pkg::CMD_LOAD: begin
        end
        i2cms_pkg::CMD_START_WR: begin
          if (head_i.ok) begin
            target_d        = head_i.target;
            tx_total_d      = cnt_ext[CW-1:0];
            tx_pos_d        = '0;
            phase_d         = i2cms_pkg::PH_WR_ADDR;
            busy_d          = 1'b1;
            res.accepted    = 1'b1;
            res.action      = i2cms_pkg::ACT_ADDR_WR;
            res.bus_address = {head_i.target, 1'b0};
          end
        end
        i2cms_pkg::CMD_START_RD: begin
          if (head_i.ok) begin
            target_d        = head_i.target;
            rx_total_d      = head_i.byte_count;
            rx_pos_d        = '0;
            phase_d         = i2cms_pkg::PH_RD_ADDR;
            busy_d          = 1'b1;
            res.accepted    = 1'b1;
            res.action      = head_i.single ? i2cms_pkg::ACT_ADDR_RD1
                                            : i2cms_pkg::ACT_ADDR_RD;
            res.bus_address = {head_i.target, 1'b1};
          end
        end
        i2cms_pkg::CMD_BUS_EVENT: begin
          if (ph == i2cms_pkg::PH_WR_ADDR_ACK || ph == i2cms_pkg::PH_WR_DATA_ACK) begin
            phase_d = ph;
            if (tx_pos_q < tx_total_q && tx_pos_q < CW'(TX_DEPTH)) begin
              res.action  = i2cms_pkg::ACT_DATA;
              res.tx_byte = rd_q;
              tx_pos_d    = tx_pos_q + 1'b1;
            end else begin
              res.action = i2cms_pkg::ACT_STOP;
              busy_d     = 1'b0;
            end
          end else if (ph == i2cms_pkg::PH_RD_ACK) begin
            phase_d      = i2cms_pkg::PH_RD_ACK;
            res.rx_byte  = head_i.data_byte;
            res.rx_valid = 1'b1;
            if (rx_need > {1'b0, rx_total_q}) begin
              res.action  = i2cms_pkg::ACT_NACK_STOP;
              res.rx_last = 1'b1;
              busy_d      = 1'b0;
            end else begin
              res.action = i2cms_pkg::ACT_ACK_CONT;
            end
            rx_pos_d = rx_pos_q + 1'b1;
          end else if (ph == i2cms_pkg::PH_RD_NACK) begin
            res.rx_byte  = head_i.data_byte;
            res.rx_valid = 1'b1;
            res.rx_last  = 1'b1;
            rx_pos_d     = rx_pos_q + 1'b1;
            phase_d      = i2cms_pkg::PH_IDLE;
            busy_d       = 1'b0;
          end else begin
            // Arbitration loss, bus error or a NACK on an address or written byte: release the bus.
            res.action      = i2cms_pkg::ACT_RECOVERY;
            res.bus_address = {target_q, 1'b0};
            phase_d         = i2cms_pkg::PH_IDLE;
            busy_d          = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    res.busy_res = busy_d;
    res.phase    = (head_i.kind == i2cms_pkg::CMD_BUS_EVENT) ? ph : phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cms_pkg::PH_IDLE;
      tx_total_q  <= '0;
      tx_pos_q    <= '0;
      rx_total_q  <= '0;
      rx_pos_q    <= '0;
      target_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      tx_total_q <= tx_total_d;
      tx_pos_q   <= tx_pos_d;
      rx_total_q <= rx_total_d;
      rx_pos_q   <= rx_pos_d;
      target_q   <= target_d;
      busy_q     <= busy_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  // The byte at the next send position is read ahead, so a data action
  // uses registered memory output. A load to that position is forwarded.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= head_i.data_byte;
    end
    if (mem_we && mem_waddr == mem_raddr) begin
      rd_q <= head_i.data_byte;
    end else begin
      rd_q <= mem[mem_raddr];
    end
  end

  a_pos_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_pos_q <= tx_total_q)
    else $error("send position ran past the write length");

  a_total_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_total_q <= CW'(TX_DEPTH))
    else $error("write length exceeds the transmit store");

  a_last_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rx_last) |-> !out_q.busy_res)
    else $error("last received byte left the transfer busy");

  a_load_no_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.kind == i2cms_pkg::CMD_LOAD) |=>
      (out_q.action == i2cms_pkg::ACT_NONE && !out_q.accepted))
    else $error("load transaction produced a bus action");

endmodule

/* design/i2c_master_transaction_sequencer_top.sv */
// I2C master transaction sequencer.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one transaction per
// cycle while in_ready_o is high: a transmit byte load, a start write, a start
// read or a bus event. Every input transaction yields exactly one result
// transaction on the output channel (out_valid_o/out_ready_i/out_data_o), in
// order, carrying the bus action, address or data byte, any received byte,
// busy and phase. A front end decodes each transaction into a two-entry queue;
// the back end pops one entry per cycle while the output register is free or
// being read, updates the transfer state and loads the output register. A
// result is registered in a queue entry and then in the output register, and
// the rate is one transaction per cycle while out_ready_i stays high.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and in_ready_o drops once both queue entries are taken.
// Reset (rst_ni low, asynchronous) empties the queue and output register,
// returns the phase to idle and clears counts, positions, target and busy.
// The transmit store is not cleared; only loaded entries may be sent.
module i2c_master_transaction_sequencer_top #(
  parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  i2cms_pkg::req_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i2cms_pkg::res_t out_data_o
);

  i2cms_pkg::cls_t cls, head;
  logic            full, head_valid, pop;

  assign in_ready_o = !full;

  i2cms_front #(
    .TX_DEPTH(TX_DEPTH)
  ) u_front (
    .req_i(in_data_i),
    .cls_o(cls)
  );

  i2cms_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  i2cms_back #(
    .TX_DEPTH(TX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
